[hw/rtl/uart_line_assembler_with_queue_macros.svh]
// Assertion macros for the line assembler.
`ifndef UART_LINE_ASSEMBLER_WITH_QUEUE_MACROS_SVH
`define UART_LINE_ASSEMBLER_WITH_QUEUE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ULAQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ULAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ulaq_pkg.sv]
`timescale 1ns / 1ps

package ulaq_pkg;

  localparam int LINE_BYTES  = 64;
  localparam int QUEUE_LINES = 4;

  // one spare physical slot holds the line being assembled
  localparam int SLOTS     = QUEUE_LINES + 1;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int IDX_W     = $clog2(LINE_BYTES);
  localparam int CNT_W     = $clog2(QUEUE_LINES + 1);
  localparam int MEM_DEPTH = SLOTS << IDX_W;

  localparam logic [IDX_W-1:0]  MAX_FILL   = IDX_W'(LINE_BYTES - 1);
  localparam logic [CNT_W-1:0]  QUEUE_FULL = CNT_W'(QUEUE_LINES);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_ERR   = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam int FLAG_LINE_OVF  = 0;
  localparam int FLAG_QUEUE_OVF = 1;

  typedef struct packed {
    logic take_byte;
    logic rx_err;
    logic fetch;
    logic rd_step;
  } cmd_t;

  typedef struct packed {
    logic q_empty;
    logic last_read;
    logic out_free;
  } sts_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

endpackage

[hw/rtl/ulaq_ctrl.sv]
`timescale 1ns / 1ps

module ulaq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     op,
  output logic           in_stall,
  input  ulaq_pkg::sts_t sts,
  output ulaq_pkg::cmd_t cmd
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t state;
  logic   accept;

  assign in_stall = (state == RUN) || !sts.out_free;
  assign accept   = in_valid && !in_stall;

  assign cmd.take_byte = accept && (op == ulaq_pkg::OP_BYTE);
  assign cmd.rx_err    = accept && (op == ulaq_pkg::OP_ERR);
  assign cmd.fetch     = accept && (op == ulaq_pkg::OP_FETCH);
  assign cmd.rd_step   = (state == RUN) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.fetch && !sts.q_empty) state <= RUN;
        end
        RUN: begin
          if (cmd.rd_step && sts.last_read) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/ulaq_dp.sv]
`timescale 1ns / 1ps
`include "uart_line_assembler_with_queue_macros.svh"

module ulaq_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     rx_byte,
  input  ulaq_pkg::cmd_t cmd,
  output ulaq_pkg::sts_t sts,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [7:0]     line_char,
  output logic           last_char,
  output logic           queue_empty,
  output logic           line_overflow,
  output logic           queue_overflow
);

  logic [7:0]                   mem [ulaq_pkg::MEM_DEPTH];
  logic [ulaq_pkg::IDX_W-1:0]   lengths [ulaq_pkg::SLOTS];

  logic [ulaq_pkg::IDX_W-1:0]   fill;
  logic [ulaq_pkg::IDX_W-1:0]   rd_idx;
  logic [ulaq_pkg::SLOT_W-1:0]  wslot;
  logic [ulaq_pkg::SLOT_W-1:0]  rslot;
  logic [ulaq_pkg::CNT_W-1:0]   count;
  logic [1:0]                   pending;
  logic [1:0]                   snap;

  logic [7:0]                   mem_q;
  logic                         empty_q;
  logic                         last_q;
  logic                         lovf_q;
  logic                         qovf_q;

  logic                         is_term;
  logic                         fill_ok;
  logic                         commit;
  logic                         fetch_empty;
  logic                         last_read;
  logic [ulaq_pkg::IDX_W-1:0]   len;

  assign is_term     = (rx_byte == ulaq_pkg::CH_LF) || (rx_byte == ulaq_pkg::CH_CR);
  assign fill_ok     = fill < ulaq_pkg::MAX_FILL;
  assign commit      = cmd.take_byte && is_term && (fill != '0)
                       && (count != ulaq_pkg::QUEUE_FULL);
  assign fetch_empty = cmd.fetch && (count == '0);
  assign len         = lengths[rslot];
  assign last_read   = ({1'b0, rd_idx} + 1'b1) == {1'b0, len};

  assign sts.q_empty   = (count == '0);
  assign sts.last_read = last_read;
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rd_idx    <= '0;
      wslot     <= '0;
      rslot     <= '0;
      count     <= '0;
      pending   <= '0;
      snap      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take_byte) begin
        if (is_term) begin
          fill <= '0;
          if (fill != '0 && count == ulaq_pkg::QUEUE_FULL)
            pending[ulaq_pkg::FLAG_QUEUE_OVF] <= 1'b1;
          if (commit) begin
            wslot <= ulaq_pkg::slot_inc(wslot);
            count <= count + 1'b1;
          end
        end else if (fill_ok) begin
          fill <= fill + 1'b1;
        end else begin
          fill <= '0;
          pending[ulaq_pkg::FLAG_LINE_OVF] <= 1'b1;
        end
      end
      if (cmd.rx_err) fill <= '0;
      if (cmd.fetch) begin
        pending <= '0;
        snap    <= pending;
        rd_idx  <= '0;
      end
      if (cmd.rd_step) begin
        snap <= '0;
        if (last_read) begin
          rd_idx <= '0;
          rslot  <= ulaq_pkg::slot_inc(rslot);
          count  <= count - 1'b1;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      if (fetch_empty || cmd.rd_step) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // line storage: assembly writes into the spare slot, fetch reads the oldest
  always_ff @(posedge clk) begin
    if (cmd.take_byte && !is_term && fill_ok) mem[{wslot, fill}] <= rx_byte;
    if (cmd.rd_step) mem_q <= mem[{rslot, rd_idx}];
  end

  always_ff @(posedge clk) begin
    if (commit) lengths[wslot] <= fill;
    if (cmd.rd_step) begin
      empty_q <= 1'b0;
      last_q  <= last_read;
      lovf_q  <= snap[ulaq_pkg::FLAG_LINE_OVF];
      qovf_q  <= snap[ulaq_pkg::FLAG_QUEUE_OVF];
    end else if (fetch_empty) begin
      empty_q <= 1'b1;
      last_q  <= 1'b1;
      lovf_q  <= pending[ulaq_pkg::FLAG_LINE_OVF];
      qovf_q  <= pending[ulaq_pkg::FLAG_QUEUE_OVF];
    end
  end

  assign line_char      = empty_q ? 8'h00 : mem_q;
  assign last_char      = last_q;
  assign queue_empty    = empty_q;
  assign line_overflow  = lovf_q;
  assign queue_overflow = qovf_q;

  `ULAQ_ASSERT(a_pop_nonempty, cmd.rd_step, count != '0, "read step on empty queue")
  `ULAQ_ASSERT_NEXT(a_commit_count, commit, count == $past(count) + 1'b1, "commit lost")
  `ULAQ_ASSERT(a_empty_last, out_valid && empty_q, last_q, "empty result not last")

endmodule

[hw/rtl/uart_line_assembler_with_queue.sv]
`timescale 1ns / 1ps
// Byte and error words give no result; an empty-queue fetch gives its result the cycle
//   after accept, and a line fetch enters RUN, then gives one char per cycle, set by the
//   single read port of the line memory, unless out_stall holds it. Input is one word per
//   cycle while in_stall is low; a fetch run holds off input until its last char is taken.
// Reset (rst, synchronous, active high) clears fill, slots, count, flags and output valid;
//   the line memory and length table are not cleared and need no clearing pass.

module uart_line_assembler_with_queue (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] line_char,
  output logic       last_char,
  output logic       queue_empty,
  output logic       line_overflow,
  output logic       queue_overflow
);

  // Structure: the memory is a ring of QUEUE_LINES+1 slots. The slot after the
  // newest queued line is always free and doubles as the assembly buffer, so
  // ending a line is just a pointer bump - no copy loop. A full queue drops the
  // assembled line and sets the queue-overflow flag.

  ulaq_pkg::cmd_t cmd;
  ulaq_pkg::sts_t sts;

  // controller: accepts words, sequences the fetch run one char per step
  ulaq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: line memory, slot pointers, sticky flags, result register
  ulaq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .line_char      (line_char),
    .last_char      (last_char),
    .queue_empty    (queue_empty),
    .line_overflow  (line_overflow),
    .queue_overflow (queue_overflow)
  );

endmodule
